[hw/rtl/timed_task_slot_scheduler_defines.svh]
// assertion macros for the timed task slot scheduler
// no dependencies; included by files that carry concurrent checks
`ifndef TIMED_TASK_SLOT_SCHEDULER_DEFINES_SVH
`define TIMED_TASK_SLOT_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tts check failed");

// next-cycle implication, disabled during reset
`define TTS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tts check failed");

`endif

[hw/rtl/tts_pkg.sv]
// shared types and constants of the timed task slot scheduler
// no dependencies; used by timed_task_slot_scheduler
package tts_pkg;

  localparam int TASK_SLOTS  = 8;
  localparam int TIME_BITS   = 32;
  localparam int PERIOD_BITS = 24;
  localparam int TAG_BITS    = 8;
  localparam int MAX_FIRES   = 8;

  localparam int SLOT_BITS = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int FIRE_BITS = $clog2(MAX_FIRES + 1);
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(TASK_SLOTS - 1);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_APPEND = 2'd1,
    OP_SCHED  = 2'd2,
    OP_REARM  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DONE     = 2'd0,
    KIND_FIRED    = 2'd1,
    KIND_APPENDED = 2'd2,
    KIND_FULL     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_EMIT
  } sched_state_t;

  // one row of the slot table memory
  typedef struct packed {
    logic [TIME_BITS-1:0]   due;
    logic [PERIOD_BITS-1:0] period;
    logic [TAG_BITS-1:0]    tag;
    logic                   one_shot;
  } slot_entry_t;

  // one result as it leaves the block
  typedef struct packed {
    kind_t      kind;
    logic [2:0] slot;
    logic [7:0] tag;
    logic       last;
  } result_t;

endpackage

[hw/rtl/tts_ram.sv]
// generic single-write, single-read RAM with registered read data
// no dependencies; used by timed_task_slot_scheduler
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data on the next cycle and held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/timed_task_slot_scheduler.sv]
// timed task slot scheduler: tick counter and a table of timed task slots
// depends on tts_pkg, tts_ram and timed_task_slot_scheduler_defines.svh
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_ready  | op, slot_index, period, task_tag, one_shot,
//          |                    | start_paused
//  out     | out_valid/out_ready| kind, slot_out, tag_out, last
//
// tick and append: action at the transfer, then the result register
// rearm: read of the slot row, write back, result
// schedule pass: one slot row read per cycle from the table memory, except that
// the scan stalls on a fire while an earlier fire is held and the output is busy
// reset clears the tick counter and the pause marks and marks every slot empty; the table memory needs none
// a new input is taken once the previous item's last result is in the output
// register, even while that register still waits for out_ready
module timed_task_slot_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [2:0]  slot_index,
  input  logic [23:0] period,
  input  logic [7:0]  task_tag,
  input  logic        one_shot,
  input  logic        start_paused,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [2:0]  slot_out,
  output logic [7:0]  tag_out,
  output logic        last
);

`include "timed_task_slot_scheduler_defines.svh"

  localparam int EntryW = $bits(tts_pkg::slot_entry_t);

  tts_pkg::sched_state_t state, state_next;

  logic [tts_pkg::TIME_BITS-1:0]  now_ticks;
  logic [tts_pkg::TASK_SLOTS-1:0] empty_mark;
  logic [tts_pkg::TASK_SLOTS-1:0] paused_mark;
  logic [2:0]                     idx_q;
  logic [tts_pkg::SLOT_BITS-1:0]  scan_slot;
  logic [tts_pkg::FIRE_BITS-1:0]  fire_cnt;
  logic                           held_valid;
  logic [2:0]                     held_slot;
  logic [7:0]                     held_tag;
  tts_pkg::result_t               res;
  tts_pkg::result_t               out_res;

  // handshake helpers
  logic accept;
  logic out_free;

  // memory port
  logic                          ram_we, ram_re;
  logic [tts_pkg::SLOT_BITS-1:0] ram_waddr, ram_raddr;
  logic [EntryW-1:0]             ram_rdata;
  tts_pkg::slot_entry_t          ram_wdata;
  tts_pkg::slot_entry_t          rd;

  // control from the datapath control block
  logic                          tick_inc;
  logic                          empty_clr;
  logic                          paused_we;
  logic [tts_pkg::SLOT_BITS-1:0] paused_idx;
  logic                          paused_val;
  logic                          res_load;
  tts_pkg::result_t              res_data;
  logic                          out_load;
  tts_pkg::result_t              out_data;
  logic                          scan_start;
  logic                          scan_adv;
  logic                          held_load;
  logic                          held_clr;

  // slot search and scan evaluation
  logic                          free_found;
  logic [tts_pkg::SLOT_BITS-1:0] free_slot;
  logic                          rearm_ok;
  logic                          fire;
  logic                          scan_go;
  logic                          scan_end;

  assign in_ready = (state == tts_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign rd       = tts_pkg::slot_entry_t'(ram_rdata);

  // slot table memory
  tts_ram #(
    .WIDTH(EntryW),
    .DEPTH(tts_pkg::TASK_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // lowest empty slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = tts_pkg::TASK_SLOTS - 1; s >= 0; s--) begin
      if (empty_mark[s]) begin
        free_found = 1'b1;
        free_slot  = tts_pkg::SLOT_BITS'(s);
      end
    end
  end

  // rearm applies only to an in-range slot that holds a task
  assign rearm_ok = (32'(idx_q) < 32'(tts_pkg::TASK_SLOTS)) &&
                    !empty_mark[tts_pkg::SLOT_BITS'(idx_q)];

  // scan: the row of scan_slot is on the read data
  assign fire = !empty_mark[scan_slot] && !paused_mark[scan_slot] &&
                (rd.due <= now_ticks) &&
                (fire_cnt < tts_pkg::FIRE_BITS'(tts_pkg::MAX_FIRES));
  assign scan_go  = !(fire && held_valid && !out_free);
  assign scan_end = (scan_slot == tts_pkg::SLOT_LAST);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tts_pkg::S_IDLE: begin
        if (accept) begin
          case (tts_pkg::op_t'(op))
            tts_pkg::OP_REARM: state_next = tts_pkg::S_RMW;
            tts_pkg::OP_SCHED: state_next = tts_pkg::S_SCAN;
            default:           state_next = tts_pkg::S_EMIT;
          endcase
        end
      end
      tts_pkg::S_RMW: state_next = tts_pkg::S_EMIT;
      tts_pkg::S_SCAN: begin
        if (scan_go && scan_end) begin
          state_next = tts_pkg::S_EMIT;
        end
      end
      tts_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = tts_pkg::S_IDLE;
        end
      end
      default: state_next = tts_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = rd;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    tick_inc   = 1'b0;
    empty_clr  = 1'b0;
    paused_we  = 1'b0;
    paused_idx = '0;
    paused_val = 1'b0;
    res_load   = 1'b0;
    res_data   = '{tts_pkg::KIND_DONE, 3'd0, 8'd0, 1'b1};
    out_load   = 1'b0;
    out_data   = res;
    scan_start = 1'b0;
    scan_adv   = 1'b0;
    held_load  = 1'b0;
    held_clr   = 1'b0;
    case (state)
      tts_pkg::S_IDLE: begin
        if (accept) begin
          case (tts_pkg::op_t'(op))
            tts_pkg::OP_TICK: begin
              tick_inc = 1'b1;
              res_load = 1'b1;
            end
            tts_pkg::OP_APPEND: begin
              res_load = 1'b1;
              if (free_found) begin
                ram_we             = 1'b1;
                ram_waddr          = free_slot;
                ram_wdata.due      = now_ticks + tts_pkg::TIME_BITS'(period);
                ram_wdata.period   = tts_pkg::PERIOD_BITS'(period);
                ram_wdata.tag      = tts_pkg::TAG_BITS'(task_tag);
                ram_wdata.one_shot = one_shot;
                empty_clr          = 1'b1;
                paused_we          = 1'b1;
                paused_idx         = free_slot;
                paused_val         = start_paused;
                res_data = '{tts_pkg::KIND_APPENDED, 3'(free_slot), 8'd0, 1'b1};
              end else begin
                res_data = '{tts_pkg::KIND_FULL, 3'd0, 8'd0, 1'b1};
              end
            end
            tts_pkg::OP_REARM: begin
              ram_re    = 1'b1;
              ram_raddr = tts_pkg::SLOT_BITS'(slot_index);
            end
            tts_pkg::OP_SCHED: begin
              ram_re     = 1'b1;
              ram_raddr  = '0;
              scan_start = 1'b1;
              held_clr   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      tts_pkg::S_RMW: begin
        res_load = 1'b1;
        res_data = '{tts_pkg::KIND_DONE, idx_q, 8'd0, 1'b1};
        if (rearm_ok) begin
          ram_we        = 1'b1;
          ram_waddr     = tts_pkg::SLOT_BITS'(idx_q);
          ram_wdata.due = now_ticks + tts_pkg::TIME_BITS'(rd.period);
          paused_we     = 1'b1;
          paused_idx    = tts_pkg::SLOT_BITS'(idx_q);
          paused_val    = 1'b0;
        end
      end
      tts_pkg::S_SCAN: begin
        if (scan_go) begin
          scan_adv = 1'b1;
          if (fire) begin
            // one-shot slots pause, periodic ones reload their due time
            if (rd.one_shot) begin
              paused_we  = 1'b1;
              paused_idx = scan_slot;
              paused_val = 1'b1;
            end else begin
              ram_we        = 1'b1;
              ram_waddr     = scan_slot;
              ram_wdata.due = now_ticks + tts_pkg::TIME_BITS'(rd.period);
            end
            // an earlier fire is now known not to be the final one
            if (held_valid) begin
              out_load = 1'b1;
              out_data = '{tts_pkg::KIND_FIRED, held_slot, held_tag, 1'b0};
            end
          end
          if (scan_end) begin
            held_clr = 1'b1;
            res_load = 1'b1;
            if (fire) begin
              res_data = '{tts_pkg::KIND_FIRED, 3'(scan_slot), 8'(rd.tag), 1'b1};
            end else if (held_valid) begin
              res_data = '{tts_pkg::KIND_FIRED, held_slot, held_tag, 1'b1};
            end
          end else begin
            held_load = fire;
            ram_re    = 1'b1;
            ram_raddr = scan_slot + tts_pkg::SLOT_BITS'(1);
          end
        end
      end
      tts_pkg::S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tts_pkg::S_IDLE;
      now_ticks   <= '0;
      empty_mark  <= '1;
      paused_mark <= '0;
      out_valid   <= 1'b0;
      held_valid  <= 1'b0;
      scan_slot   <= '0;
      fire_cnt    <= '0;
    end else begin
      state <= state_next;
      if (tick_inc) begin
        now_ticks <= now_ticks + tts_pkg::TIME_BITS'(1);
      end
      if (empty_clr) begin
        empty_mark[free_slot] <= 1'b0;
      end
      if (paused_we) begin
        paused_mark[paused_idx] <= paused_val;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (held_clr) begin
        held_valid <= 1'b0;
      end else if (held_load) begin
        held_valid <= 1'b1;
      end
      if (scan_start) begin
        scan_slot <= '0;
        fire_cnt  <= '0;
      end else if (scan_adv) begin
        scan_slot <= scan_slot + tts_pkg::SLOT_BITS'(1);
        if (fire) begin
          fire_cnt <= fire_cnt + tts_pkg::FIRE_BITS'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_q <= slot_index;
    end
    if (held_load) begin
      held_slot <= 3'(scan_slot);
      held_tag  <= 8'(rd.tag);
    end
    if (res_load) begin
      res <= res_data;
    end
    if (out_load) begin
      out_res <= out_data;
    end
  end

  // output ports
  assign kind     = out_res.kind;
  assign slot_out = out_res.slot;
  assign tag_out  = out_res.tag;
  assign last     = out_res.last;

  // checks
  `TTS_ASSERT_IMP(a_held_only_in_scan, clk, rst, held_valid, state == tts_pkg::S_SCAN)
  `TTS_ASSERT_IMP(a_rw_disjoint, clk, rst, ram_we && ram_re, ram_waddr != ram_raddr)
  `TTS_ASSERT_NXT(a_scan_exit, clk, rst, state == tts_pkg::S_SCAN && scan_go && scan_end, state == tts_pkg::S_EMIT && !held_valid)
  `TTS_ASSERT_IMP(a_fire_bound, clk, rst, state == tts_pkg::S_SCAN, fire_cnt <= tts_pkg::FIRE_BITS'(tts_pkg::MAX_FIRES))

endmodule
